### design/sorted_time_range_finder_top_defines.svh
// Assertion macros shared by the sorted time range finder RTL.
// Requires a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef SORTED_TIME_RANGE_FINDER_TOP_DEFINES_SVH
`define SORTED_TIME_RANGE_FINDER_TOP_DEFINES_SVH

// Checked on every rising clock edge while reset is released
`define STRF_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Checked on every rising clock edge, reset included
`define STRF_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

### design/strf_pkg.sv
// Package for the sorted time range finder: beat types, command and status codes.
// No dependencies.
package strf_pkg;

    localparam int TIME_W = 63;
    localparam int IDX_W  = 11;

    // Command codes
    localparam logic [1:0] CMD_CLEAR  = 2'd0;
    localparam logic [1:0] CMD_APPEND = 2'd1;
    localparam logic [1:0] CMD_QUERY  = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FOUND = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [TIME_W-1:0] time_value;
        logic [TIME_W-1:0] end_time;
    } t_in;

    typedef struct packed {
        logic [1:0]       status;
        logic [IDX_W-1:0] start_index;
        logic [IDX_W-1:0] end_index;
    } t_out;

endpackage

### design/strf_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module strf_ram #(
    parameter int WIDTH = 63,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### design/sorted_time_range_finder_top.sv
// Sorted time range finder: top level with command sequencer and search engine.
// Depends on strf_pkg, strf_ram and sorted_time_range_finder_top_defines.svh.
// Usage:
//   A command beat is taken at a rising edge with start high and busy low.
//   i_item.cmd selects clear, append or range query; i_item.time_value is the
//   timestamp to append or the inclusive query start; i_item.end_time is the
//   exclusive query end. Every command gives exactly one result beat on
//   o_result, marked by o_done for a single cycle.
//   Clear, append and unused commands finish in one cycle: o_done rises the
//   cycle after the command beat and busy stays low, so one such command can
//   be issued every cycle.
//   A query that can be answered at once (empty store, start not below end)
//   also keeps busy low. Otherwise busy goes high and two lower-bound binary
//   searches run through one comparator and the single read port of the
//   timestamp RAM, at most 3 probes per halving step.
//   The result appears in the cycle busy falls; the receiver cannot stall.
//   Reset zeroes the record count; RAM contents stay, only entries below it are read.
`include "sorted_time_range_finder_top_defines.svh"

module sorted_time_range_finder_top
    import strf_pkg::*;
#(
    parameter int DEPTH = 1024
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_in  i_item,
    output logic o_done,
    output t_out o_result
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int AW = $clog2(DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
    localparam logic [CW-1:0] ONE_C   = CW'(1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_HI_CHK,
        S_LO_CHK,
        S_MID_CHK,
        S_START2
    } t_state;

    // control registers
    t_state          r_state,  n_state;
    logic [CW-1:0]   r_count,  n_count;
    logic            r_done,   n_done;
    logic            r_phase,  n_phase;
    // search and payload registers
    logic [CW-1:0]   r_lo,     n_lo;
    logic [CW-1:0]   r_hi,     n_hi;
    logic [CW-1:0]   r_first,  n_first;
    logic [TIME_W-1:0] r_tval, n_tval;
    logic [TIME_W-1:0] r_tend, n_tend;
    logic [1:0]      r_status, n_status;
    logic [CW-1:0]   r_sidx,   n_sidx;
    logic [CW-1:0]   r_eidx,   n_eidx;

    // RAM port signals
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [AW-1:0]     ram_raddr;
    logic [TIME_W-1:0] ram_rdata;

    // search helpers
    logic [CW:0]       mid_sum;
    logic [CW-1:0]     mid;
    logic [CW-1:0]     mid_m1;
    logic [CW-1:0]     cnt_m1;
    logic [TIME_W-1:0] key;
    logic              key_gt;
    logic              fin;
    logic [CW-1:0]     fin_pos;
    logic              accept;
    logic [CW+IDX_W-1:0] sidx_ext;
    logic [CW+IDX_W-1:0] eidx_ext;

    strf_ram #(
        .WIDTH (TIME_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_item.time_value),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // shared comparator: search key strictly above the probed record
    assign key    = r_phase ? r_tend : r_tval;
    assign key_gt = key > ram_rdata;

    assign mid_sum = {1'b0, r_lo} + {1'b0, r_hi};
    assign mid     = mid_sum[CW:1];
    assign mid_m1  = mid - ONE_C;
    assign cnt_m1  = r_count - ONE_C;

    assign accept    = start && (r_state == S_IDLE);
    assign ram_we    = accept && (i_item.cmd == CMD_APPEND) && (r_count < DEPTH_C);
    assign ram_waddr = r_count[AW-1:0];

    // probe address for the next cycle
    always_comb begin
        case (r_state)
            S_IDLE:    ram_raddr = cnt_m1[AW-1:0];
            S_START2:  ram_raddr = cnt_m1[AW-1:0];
            S_HI_CHK:  ram_raddr = r_lo[AW-1:0];
            S_LO_CHK:  ram_raddr = mid[AW-1:0];
            S_MID_CHK: ram_raddr = key_gt ? r_hi[AW-1:0] : mid_m1[AW-1:0];
            default:   ram_raddr = cnt_m1[AW-1:0];
        endcase
    end

    // sequencer next state
    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_done   = 1'b0;
        n_phase  = r_phase;
        n_lo     = r_lo;
        n_hi     = r_hi;
        n_first  = r_first;
        n_tval   = r_tval;
        n_tend   = r_tend;
        n_status = r_status;
        n_sidx   = r_sidx;
        n_eidx   = r_eidx;
        fin      = 1'b0;
        fin_pos  = mid;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_tval   = i_item.time_value;
                    n_tend   = i_item.end_time;
                    n_status = ST_DONE;
                    n_sidx   = '0;
                    n_eidx   = '0;
                    case (i_item.cmd)
                        CMD_CLEAR: begin
                            n_count = '0;
                            n_done  = 1'b1;
                        end
                        CMD_APPEND: begin
                            n_done = 1'b1;
                            if (r_count < DEPTH_C) begin
                                n_count = r_count + ONE_C;
                            end else begin
                                n_status = ST_FULL;
                            end
                        end
                        CMD_QUERY: begin
                            if ((r_count == '0) || !(i_item.time_value < i_item.end_time)) begin
                                n_status = ST_EMPTY;
                                n_done   = 1'b1;
                            end else begin
                                n_phase = 1'b0;
                                n_lo    = '0;
                                n_hi    = cnt_m1;
                                n_state = S_HI_CHK;
                            end
                        end
                        default: begin
                            n_done = 1'b1;
                        end
                    endcase
                end
            end
            S_HI_CHK: begin
                // every record below key: bound is one past the top
                if (key_gt) begin
                    fin     = 1'b1;
                    fin_pos = r_hi + ONE_C;
                end else begin
                    n_state = S_LO_CHK;
                end
            end
            S_LO_CHK: begin
                if (!key_gt) begin
                    fin     = 1'b1;
                    fin_pos = r_lo;
                end else begin
                    n_state = S_MID_CHK;
                end
            end
            S_MID_CHK: begin
                if (key_gt) begin
                    if (mid < r_hi) begin
                        n_lo    = mid + ONE_C;
                        n_state = S_HI_CHK;
                    end else begin
                        fin = 1'b1;
                    end
                end else begin
                    if (r_lo < mid) begin
                        n_hi    = mid_m1;
                        n_state = S_HI_CHK;
                    end else begin
                        fin = 1'b1;
                    end
                end
            end
            S_START2: begin
                n_state = S_HI_CHK;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // end of one search
        if (fin) begin
            if (!r_phase) begin
                if (fin_pos < r_count) begin
                    n_first = fin_pos;
                    n_phase = 1'b1;
                    n_lo    = fin_pos;
                    n_hi    = cnt_m1;
                    n_state = S_START2;
                end else begin
                    n_status = ST_EMPTY;
                    n_done   = 1'b1;
                    n_state  = S_IDLE;
                end
            end else begin
                n_done  = 1'b1;
                n_state = S_IDLE;
                if (r_first < fin_pos) begin
                    n_status = ST_FOUND;
                    n_sidx   = r_first;
                    n_eidx   = fin_pos;
                end else begin
                    n_status = ST_EMPTY;
                end
            end
        end
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_done  <= 1'b0;
            r_phase <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_done   <= n_done;
            r_phase  <= n_phase;
            r_lo     <= n_lo;
            r_hi     <= n_hi;
            r_first  <= n_first;
            r_tval   <= n_tval;
            r_tend   <= n_tend;
            r_status <= n_status;
            r_sidx   <= n_sidx;
            r_eidx   <= n_eidx;
        end
    end

    // result beat, indices cut to the field width
    assign sidx_ext = {{IDX_W{1'b0}}, r_sidx};
    assign eidx_ext = {{IDX_W{1'b0}}, r_eidx};

    assign busy                 = (r_state != S_IDLE);
    assign o_done               = r_done;
    assign o_result.status      = r_status;
    assign o_result.start_index = sidx_ext[IDX_W-1:0];
    assign o_result.end_index   = eidx_ext[IDX_W-1:0];

    // checks
    `STRF_ASSERT(a_count_bound, r_count <= DEPTH_C, "record count beyond depth")
    `STRF_ASSERT(a_done_cause, o_done |-> ($past(start) || $past(busy)), "result without command")
    `STRF_ASSERT(a_busy_end, $fell(busy) |-> o_done, "search ended without result")
    `STRF_ASSERT(a_window, (r_state == S_HI_CHK) |-> (r_lo <= r_hi), "search window inverted")
    `STRF_ASSERT(a_found_order, (o_done && (r_status == ST_FOUND)) |-> (r_sidx < r_eidx), "found range not ordered")

endmodule

### bench/tb.sv
// Self-checking bench for sorted_time_range_finder_top: directed and random command beats.
// A shadow copy of the timestamp store predicts every result. Depends on strf_pkg and sorted_time_range_finder_top.
`timescale 1ns / 100ps

module tb
    import strf_pkg::*;
();

    localparam int          DEPTH        = 1024;
    localparam logic [1:0]  CMD_UNUSED   = 2'd3;
    localparam logic [62:0] STAMP_MAX    = 63'h7FFF_FFFF_FFFF_FFFF;
    localparam int          TOTAL_BEATS  = 1400;
    localparam int          STALL_LIMIT  = 1000;
    localparam int          DRAIN_CYCLES = 80;

    // Shadow of the store: predicts one answer per command beat, checks results in order
    class time_index_tracker;
        bit [62:0]   shadow_times [DEPTH];
        int unsigned shadow_count;
        t_out        pending_answers [$];
        int          mismatches;
        int          n_beats, n_found, n_empty, n_full;

        // Fixed lower-bound probe order: top, bottom, then halve
        function int unsigned lower_bound_from(int unsigned lo, bit [62:0] key);
            int unsigned hi;
            int unsigned pos;
            bit          settled;
            hi = shadow_count - 1;
            pos = shadow_count;
            settled = 1'b0;
            while (!settled && lo <= hi) begin
                if (key > shadow_times[hi]) begin
                    pos = hi + 1;
                    settled = 1'b1;
                end else if (shadow_times[lo] >= key) begin
                    pos = lo;
                    settled = 1'b1;
                end else begin
                    pos = (lo + hi) / 2;
                    if (key > shadow_times[pos]) lo = pos + 1;
                    else hi = pos - 1;
                end
            end
            return pos;
        endfunction

        function void take_command(t_in b);
            t_out        ans;
            int unsigned first;
            int unsigned last;
            ans = '0;
            ans.status = ST_DONE;
            n_beats++;
            case (b.cmd)
                CMD_CLEAR: begin
                    shadow_count = 0;
                end
                CMD_APPEND: begin
                    if (shadow_count < DEPTH) begin
                        shadow_times[shadow_count] = b.time_value;
                        shadow_count++;
                    end else begin
                        ans.status = ST_FULL;
                        n_full++;
                    end
                end
                CMD_QUERY: begin
                    ans.status = ST_EMPTY;
                    if (shadow_count != 0 && b.time_value < b.end_time) begin
                        first = lower_bound_from(0, b.time_value);
                        if (first < shadow_count) begin
                            last = lower_bound_from(first, b.end_time);
                            if (last > shadow_count) last = shadow_count;
                            if (first < last) begin
                                ans.status      = ST_FOUND;
                                ans.start_index = IDX_W'(first);
                                ans.end_index   = IDX_W'(last);
                            end
                        end
                    end
                    if (ans.status == ST_FOUND) n_found++;
                    else n_empty++;
                end
                default: ;
            endcase
            pending_answers.push_back(ans);
        endfunction

        function void check_answer(t_out got);
            t_out want;
            if (pending_answers.size() == 0) begin
                $display("%0t: result beat with none pending: status %0d start %0d end %0d",
                         $time, got.status, got.start_index, got.end_index);
                mismatches++;
                return;
            end
            want = pending_answers.pop_front();
            if (got.status !== want.status) begin
                $display("%0t: status expected %0d got %0d", $time, want.status, got.status);
                mismatches++;
            end
            if (got.start_index !== want.start_index) begin
                $display("%0t: start_index expected %0d got %0d",
                         $time, want.start_index, got.start_index);
                mismatches++;
            end
            if (got.end_index !== want.end_index) begin
                $display("%0t: end_index expected %0d got %0d",
                         $time, want.end_index, got.end_index);
                mismatches++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n = 1'b0;
    logic start   = 1'b0;
    logic busy;
    t_in  item    = '0;
    logic o_done;
    t_out o_result;

    time_index_tracker tracker;
    int                beats_sent = 0;
    int                stall_cycles = 0;
    logic [62:0]       tail_stamp = '0;

    sorted_time_range_finder_top #(.DEPTH(DEPTH)) DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (item),
        .o_done   (o_done),
        .o_result (o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Result monitor: the receiver never stalls, so every strobe is a beat
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) tracker.check_answer(o_result);
    end

    // Watchdog on cycles with no beat in either direction
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
                $display("FAIL sorted_time_range_finder_top");
                $finish;
            end
        end
    end

    function automatic logic [62:0] rand63();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[62:0];
    endfunction

    function automatic t_in beat(logic [1:0] c, logic [62:0] tv, logic [62:0] te);
        t_in b;
        b.cmd        = c;
        b.time_value = tv;
        b.end_time   = te;
        return b;
    endfunction

    // Next ascending stamp: duplicates, small and large steps, saturating at the top
    function automatic logic [62:0] next_stamp();
        logic [63:0] step;
        logic [63:0] sum;
        case ($urandom_range(9))
            0, 1:    step = '0;
            2, 3, 4: step = 64'($urandom_range(1, 3));
            5, 6, 7: step = 64'($urandom_range(1, 65535));
            8:       step = 64'($urandom) << 8;
            default: step = 64'(rand63()) >> $urandom_range(1, 62);
        endcase
        sum = {1'b0, tail_stamp} + step;
        tail_stamp = (sum > {1'b0, STAMP_MAX}) ? STAMP_MAX : sum[62:0];
        return tail_stamp;
    endfunction

    function automatic logic [62:0] nudge(logic [62:0] v);
        case ($urandom_range(3))
            0:       return (v != 0) ? v - 1 : v;
            3:       return (v != STAMP_MAX) ? v + 1 : v;
            default: return v;
        endcase
    endfunction

    // Query bounds mostly taken near stored stamps so both searches land inside the store
    function automatic t_in make_query();
        t_in         q;
        int unsigned a, b;
        logic [62:0] tmp;
        q.cmd = CMD_QUERY;
        if (tracker.shadow_count == 0 || $urandom_range(9) == 0) begin
            q.time_value = rand63();
            q.end_time   = rand63();
        end else begin
            a = $urandom_range(tracker.shadow_count - 1);
            b = $urandom_range(tracker.shadow_count - 1);
            q.time_value = nudge(tracker.shadow_times[a]);
            q.end_time   = nudge(tracker.shadow_times[b]);
            if ($urandom_range(9) < 8 && q.time_value > q.end_time) begin
                tmp          = q.time_value;
                q.time_value = q.end_time;
                q.end_time   = tmp;
            end
            if ($urandom_range(15) == 0) q.end_time = STAMP_MAX;
            if ($urandom_range(15) == 0) q.time_value = '0;
        end
        return q;
    endfunction

    // One command beat; random idle cycles ahead of it outside the steady window
    task automatic send_item(input t_in b);
        if (!(beats_sent >= 300 && beats_sent < 520)) begin
            while ($urandom_range(99) < 34) begin
                start <= 1'b0;
                @(posedge i_clk);
            end
        end
        start <= 1'b1;
        item  <= b;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        tracker.take_command(b);
        beats_sent++;
    endtask

    initial begin
        int unsigned fill;
        int unsigned pick;
        tracker = new();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty store, duplicates, extremes, degenerate ranges, unordered data
        send_item(beat(CMD_QUERY, '0, STAMP_MAX));
        send_item(beat(CMD_UNUSED, STAMP_MAX, STAMP_MAX));
        send_item(beat(CMD_APPEND, 63'd0, '0));
        send_item(beat(CMD_APPEND, 63'd5, '0));
        send_item(beat(CMD_APPEND, 63'd5, '0));
        send_item(beat(CMD_APPEND, 63'd9, '0));
        send_item(beat(CMD_QUERY, 63'd0, STAMP_MAX));
        send_item(beat(CMD_QUERY, 63'd5, 63'd9));
        send_item(beat(CMD_QUERY, 63'd5, 63'd6));
        send_item(beat(CMD_QUERY, 63'd6, 63'd6));
        send_item(beat(CMD_QUERY, 63'd9, 63'd5));
        send_item(beat(CMD_QUERY, 63'd10, STAMP_MAX));
        send_item(beat(CMD_QUERY, 63'd1, 63'd2));
        send_item(beat(CMD_QUERY, 63'd0, 63'd1));
        send_item(beat(CMD_APPEND, STAMP_MAX, '0));
        send_item(beat(CMD_QUERY, 63'd9, STAMP_MAX));
        send_item(beat(CMD_QUERY, STAMP_MAX - 1, STAMP_MAX));
        send_item(beat(CMD_APPEND, 63'd3, '0));
        send_item(beat(CMD_QUERY, 63'd4, STAMP_MAX));
        send_item(beat(CMD_CLEAR, STAMP_MAX, STAMP_MAX));
        send_item(beat(CMD_QUERY, '0, STAMP_MAX));
        send_item(beat(CMD_APPEND, STAMP_MAX, STAMP_MAX));
        send_item(beat(CMD_QUERY, '0, STAMP_MAX));
        send_item(beat(CMD_UNUSED, '0, '0));

        // Fill the store to the top with queries mixed in, then append past full
        send_item(beat(CMD_CLEAR, rand63(), rand63()));
        tail_stamp = rand63() >> $urandom_range(8, 62);
        while (tracker.shadow_count < DEPTH) begin
            if ($urandom_range(99) < 12) send_item(make_query());
            else send_item(beat(CMD_APPEND, next_stamp(), rand63()));
        end
        repeat (6) send_item(beat(CMD_APPEND, next_stamp(), rand63()));
        repeat (30) send_item(make_query());

        // Short episodes: clear, a small sorted fill, queries, some noise
        while (beats_sent < TOTAL_BEATS) begin
            send_item(beat(CMD_CLEAR, rand63(), rand63()));
            tail_stamp = ($urandom_range(3) == 0) ? '0 : rand63() >> $urandom_range(0, 62);
            fill = ($urandom_range(7) == 0) ? $urandom_range(49, 200) : $urandom_range(0, 48);
            repeat (2 * fill + 4) begin
                pick = $urandom_range(99);
                if (pick < 4)
                    send_item(beat(CMD_UNUSED, rand63(), rand63()));
                else if (pick < 9)
                    send_item(beat(CMD_APPEND, rand63(), rand63()));
                else if (pick < 55 && tracker.shadow_count < fill)
                    send_item(beat(CMD_APPEND, next_stamp(), rand63()));
                else
                    send_item(make_query());
            end
        end

        start <= 1'b0;
        while (tracker.pending_answers.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Ran %0d command beats, including a fill to %0d records and appends past full.",
                 tracker.n_beats, DEPTH);
        $display("Queries: %0d ranges found, %0d empty; %0d appends dropped on a full store.",
                 tracker.n_found, tracker.n_empty, tracker.n_full);
        if (tracker.mismatches == 0) begin
            $display("PASS sorted_time_range_finder_top");
        end else begin
            $display("FAIL sorted_time_range_finder_top");
        end
        $finish;
    end

endmodule
